FILE: sv/mlfq_scheduler_defines.svh
// ---------------------------------------------------------------------------
// mlfq_scheduler_defines
// Assertion macros shared by the scheduler RTL.
// ---------------------------------------------------------------------------
`ifndef MLFQ_SCHEDULER_DEFINES_SVH
`define MLFQ_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MLFQ_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mlfq_scheduler: invariant failed");
`define MLFQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlfq_scheduler: sequence check failed");
`else
`define MLFQ_ASSERT_ALWAYS(lbl, expr)
`define MLFQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: sv/mlfq_pkg.sv
// ---------------------------------------------------------------------------
// mlfq_pkg
// Fixed widths, event codes and register indexes of the scheduler.
// ---------------------------------------------------------------------------
package mlfq_pkg;

    localparam int NUM_LEVELS = 4;
    localparam int LV_W       = 2;
    localparam int Q_W        = 12;
    localparam int T_W        = 16;
    localparam int TIME_W     = 32;
    localparam int SB_W       = 17;
    localparam int EV_W       = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    typedef logic [EV_W-1:0] event_t;

    localparam event_t EV_LOADED   = 3'd0;
    localparam event_t EV_REJECTED = 3'd1;
    localparam event_t EV_IDLE     = 3'd2;
    localparam event_t EV_STAYS    = 3'd3;
    localparam event_t EV_DEMOTED  = 3'd4;
    localparam event_t EV_COMPLETE = 3'd5;
    localparam event_t EV_ALL_DONE = 3'd6;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_QUANTUM0 = 3'd0;
    localparam reg_idx_t REG_QUANTUM1 = 3'd1;
    localparam reg_idx_t REG_QUANTUM2 = 3'd2;
    localparam reg_idx_t REG_QUANTUM3 = 3'd3;
    localparam reg_idx_t REG_ALLOT0   = 3'd4;
    localparam reg_idx_t REG_ALLOT1   = 3'd5;
    localparam reg_idx_t REG_ALLOT2   = 3'd6;
    localparam reg_idx_t REG_BOOST    = 3'd7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

endpackage

FILE: sv/mlfq_scheduler.sv
// ---------------------------------------------------------------------------
// mlfq_scheduler
// Four-level feedback queue scheduler with process state kept in RAMs.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    operation, arrival, job_length
//  out       out_valid / out_ready  event_res, process_slot, level, start_time,
//                                   run_length, boosted
//  cfg       psel / penable         paddr, pwdata, prdata, pwrite, pready
//
// A load or an all-done step goes from S_IDLE to S_FINISH. A step that runs a
// process passes S_ADM_RD/S_ADM_CHK per admitted process (one more S_ADM_CHK
// while a loaded process has yet to arrive), S_SEL, S_EXEC1, S_EXEC2, S_FINISH;
// an idle step skips S_EXEC1/2. A boost first moves levels 1-3 to the top level.
// Reset is asynchronous and leaves all queues empty; no RAM clearing is needed.
// A new item is taken while the previous result still waits on the output.
// ---------------------------------------------------------------------------
module mlfq_scheduler #(
    parameter int MAX_PROCESSES = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       operation,
    input  logic [mlfq_pkg::T_W-1:0]                   arrival,
    input  logic [mlfq_pkg::T_W-1:0]                   job_length,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [mlfq_pkg::EV_W-1:0]                  event_res,
    output logic [$clog2(MAX_PROCESSES)-1:0]           process_slot,
    output logic [mlfq_pkg::LV_W-1:0]                  level,
    output logic [mlfq_pkg::TIME_W-1:0]                start_time,
    output logic [mlfq_pkg::Q_W-1:0]                   run_length,
    output logic                                       boosted,
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [mlfq_pkg::ADDR_W-1:0]                paddr,
    input  logic [mlfq_pkg::DATA_W-1:0]                pwdata,
    output logic [mlfq_pkg::DATA_W-1:0]                prdata,
    output logic                                       pready
);
    import mlfq_pkg::*;

    `include "mlfq_scheduler_defines.svh"

    localparam int SLOT_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_BLVL, S_BWALK, S_BNEXT, S_BSPLICE, S_ADM_RD, S_ADM_CHK,
        S_SEL, S_EXEC1, S_EXEC2, S_FINISH
    } state_t;

    state_t state_reg;

    logic [Q_W-1:0]    quantum_reg [NUM_LEVELS];
    logic [T_W-1:0]    allot_reg   [NUM_LEVELS-1];
    logic [T_W-1:0]    boost_period_reg;

    logic [SLOT_W-1:0] head_reg  [NUM_LEVELS];
    logic [SLOT_W-1:0] tail_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]  count_reg [NUM_LEVELS];

    logic [TIME_W-1:0] time_reg;
    logic [SB_W-1:0]   since_reg;
    logic [CNT_W-1:0]  loaded_reg;
    logic [CNT_W-1:0]  admitted_reg;
    logic [CNT_W-1:0]  completed_reg;
    logic [T_W-1:0]    last_arrival_reg;

    logic [LV_W-1:0]   blvl_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic [CNT_W-1:0]  walk_n_reg;
    logic [LV_W-1:0]   run_lv_reg;
    logic [SLOT_W-1:0] run_slot_reg;
    logic [Q_W-1:0]    ex_reg;

    event_t            res_ev_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [LV_W-1:0]   res_lv_reg;
    logic [TIME_W-1:0] res_start_reg;
    logic [Q_W-1:0]    res_run_reg;
    logic              res_boost_reg;

    logic              out_valid_reg;
    event_t            out_ev_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [LV_W-1:0]   out_lv_reg;
    logic [TIME_W-1:0] out_start_reg;
    logic [Q_W-1:0]    out_run_reg;
    logic              out_boost_reg;

    logic [T_W-1:0]    arr_mem  [MAX_PROCESSES];
    logic [T_W-1:0]    rem_mem  [MAX_PROCESSES];
    logic [T_W-1:0]    used_mem [MAX_PROCESSES];
    logic [SLOT_W-1:0] link_mem [MAX_PROCESSES];

    logic [T_W-1:0]    arr_rd_reg;
    logic [T_W-1:0]    rem_rd_reg;
    logic [T_W-1:0]    used_rd_reg;
    logic [SLOT_W-1:0] link_rd_reg;

    logic              arr_we, rem_we, used_we, link_we;
    logic [SLOT_W-1:0] arr_wa, rem_wa, used_wa, link_wa;
    logic [T_W-1:0]    arr_wd, rem_wd, used_wd;
    logic [SLOT_W-1:0] link_wd;
    logic              arr_re, rem_re, link_re;
    logic [SLOT_W-1:0] arr_ra, rem_ra, link_ra;

    logic              in_fire, cfg_wr, load_ok, adm_ok, any_ready;
    logic [LV_W-1:0]   sel_lv;
    logic [Q_W-1:0]    q_eff;
    logic [T_W:0]      used_sum;
    logic [T_W-1:0]    used_sat;
    logic [T_W-1:0]    rem_new;
    logic              demote;
    logic [LV_W-1:0]   push_lv;
    logic [SLOT_W-1:0] push_slot;
    logic              push_en;
    logic [CNT_W+1:0]  queued_sum;

    assign in_ready     = (state_reg == S_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign cfg_wr       = psel && penable && pwrite;
    assign pready       = 1'b1;
    assign out_valid    = out_valid_reg;
    assign event_res    = out_ev_reg;
    assign process_slot = out_slot_reg;
    assign level        = out_lv_reg;
    assign start_time   = out_start_reg;
    assign run_length   = out_run_reg;
    assign boosted      = out_boost_reg;

    always_comb
    begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_QUANTUM0: prdata = DATA_W'(quantum_reg[0]);
            REG_QUANTUM1: prdata = DATA_W'(quantum_reg[1]);
            REG_QUANTUM2: prdata = DATA_W'(quantum_reg[2]);
            REG_QUANTUM3: prdata = DATA_W'(quantum_reg[3]);
            REG_ALLOT0:   prdata = DATA_W'(allot_reg[0]);
            REG_ALLOT1:   prdata = DATA_W'(allot_reg[1]);
            REG_ALLOT2:   prdata = DATA_W'(allot_reg[2]);
            REG_BOOST:    prdata = DATA_W'(boost_period_reg);
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        load_ok = (loaded_reg < CNT_W'(MAX_PROCESSES)) && (job_length != '0) &&
                  ((loaded_reg == '0) || (arrival >= last_arrival_reg));
        adm_ok  = ({{(TIME_W-T_W){1'b0}}, arr_rd_reg} <= time_reg);
        any_ready = 1'b0;
        sel_lv    = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any_ready = 1'b1;
                sel_lv    = LV_W'(i);
            end
        end
        q_eff    = (quantum_reg[run_lv_reg] == '0) ? Q_W'(1) : quantum_reg[run_lv_reg];
        used_sum = {1'b0, used_rd_reg} + (T_W+1)'(ex_reg);
        used_sat = used_sum[T_W] ? {T_W{1'b1}} : used_sum[T_W-1:0];
        rem_new  = rem_rd_reg - T_W'(ex_reg);
        demote   = (run_lv_reg != LV_W'(NUM_LEVELS - 1)) &&
                   (allot_reg[run_lv_reg[1:0] == 2'd3 ? 2'd0 : run_lv_reg] != '0) &&
                   (used_sat >= allot_reg[run_lv_reg[1:0] == 2'd3 ? 2'd0 : run_lv_reg]);
        queued_sum = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            queued_sum = queued_sum + (CNT_W+2)'(count_reg[i]);
        end
    end

    always_comb
    begin
        push_en   = 1'b0;
        push_lv   = '0;
        push_slot = run_slot_reg;
        if (state_reg == S_ADM_CHK && adm_ok)
        begin
            push_en   = 1'b1;
            push_slot = admitted_reg[SLOT_W-1:0];
        end
        else if (state_reg == S_EXEC2 && rem_new != '0)
        begin
            push_en = 1'b1;
            push_lv = demote ? run_lv_reg + LV_W'(1) : run_lv_reg;
        end
    end

    always_comb
    begin
        arr_we  = in_fire && operation == OP_LOAD && load_ok;
        arr_wa  = loaded_reg[SLOT_W-1:0];
        arr_wd  = arrival;
        rem_we  = arr_we || state_reg == S_EXEC2;
        rem_wa  = arr_we ? loaded_reg[SLOT_W-1:0] : run_slot_reg;
        rem_wd  = arr_we ? job_length : rem_new;
        used_we = 1'b0;
        used_wa = run_slot_reg;
        used_wd = '0;
        case (state_reg)
            S_BWALK:
            begin
                used_we = 1'b1;
                used_wa = cur_reg;
            end
            S_ADM_CHK:
            begin
                used_we = adm_ok;
                used_wa = admitted_reg[SLOT_W-1:0];
            end
            S_EXEC2:
            begin
                used_we = 1'b1;
                used_wd = demote ? '0 : used_sat;
            end
            default:
            begin
                used_we = 1'b0;
            end
        endcase
        link_we = 1'b0;
        link_wa = tail_reg[0];
        link_wd = push_slot;
        if (state_reg == S_BSPLICE)
        begin
            link_we = count_reg[0] != '0;
            link_wd = head_reg[blvl_reg];
        end
        else if (push_en)
        begin
            link_we = count_reg[push_lv] != '0;
            link_wa = tail_reg[push_lv];
        end
        arr_re  = state_reg == S_ADM_RD;
        arr_ra  = admitted_reg[SLOT_W-1:0];
        rem_re  = state_reg == S_SEL;
        rem_ra  = head_reg[sel_lv];
        link_re = (state_reg == S_SEL) || (state_reg == S_BWALK);
        link_ra = (state_reg == S_SEL) ? head_reg[sel_lv] : cur_reg;
    end

    always_ff @(posedge clk)
    begin
        if (arr_we)
        begin
            arr_mem[arr_wa] <= arr_wd;
        end
        if (arr_re)
        begin
            arr_rd_reg <= arr_mem[arr_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[rem_wa] <= rem_wd;
        end
        if (rem_re)
        begin
            rem_rd_reg <= rem_mem[rem_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
        if (rem_re)
        begin
            used_rd_reg <= used_mem[rem_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[link_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg[0]   <= Q_W'(4);
            quantum_reg[1]   <= Q_W'(8);
            quantum_reg[2]   <= Q_W'(12);
            quantum_reg[3]   <= Q_W'(100);
            allot_reg[0]     <= T_W'(8);
            allot_reg[1]     <= T_W'(16);
            allot_reg[2]     <= T_W'(48);
            boost_period_reg <= T_W'(50);
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[ADDR_W-1:2]))
                REG_QUANTUM0: quantum_reg[0]   <= pwdata[Q_W-1:0];
                REG_QUANTUM1: quantum_reg[1]   <= pwdata[Q_W-1:0];
                REG_QUANTUM2: quantum_reg[2]   <= pwdata[Q_W-1:0];
                REG_QUANTUM3: quantum_reg[3]   <= pwdata[Q_W-1:0];
                REG_ALLOT0:   allot_reg[0]     <= pwdata[T_W-1:0];
                REG_ALLOT1:   allot_reg[1]     <= pwdata[T_W-1:0];
                REG_ALLOT2:   allot_reg[2]     <= pwdata[T_W-1:0];
                REG_BOOST:    boost_period_reg <= pwdata[T_W-1:0];
                default:      boost_period_reg <= boost_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            time_reg         <= '0;
            since_reg        <= '0;
            loaded_reg       <= '0;
            admitted_reg     <= '0;
            completed_reg    <= '0;
            last_arrival_reg <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            if (push_en)
            begin
                if (count_reg[push_lv] == '0)
                begin
                    head_reg[push_lv] <= push_slot;
                end
                tail_reg[push_lv]  <= push_slot;
                count_reg[push_lv] <= count_reg[push_lv] + CNT_W'(1);
            end
            case (state_reg)
                S_IDLE:
                begin
                    res_lv_reg  <= '0;
                    res_run_reg <= '0;
                    if (in_fire)
                    begin
                        if (operation == OP_LOAD)
                        begin
                            state_reg     <= S_FINISH;
                            res_start_reg <= '0;
                            res_boost_reg <= 1'b0;
                            if (load_ok)
                            begin
                                res_ev_reg       <= EV_LOADED;
                                res_slot_reg     <= loaded_reg[SLOT_W-1:0];
                                loaded_reg       <= loaded_reg + CNT_W'(1);
                                last_arrival_reg <= arrival;
                            end
                            else
                            begin
                                res_ev_reg   <= EV_REJECTED;
                                res_slot_reg <= '0;
                            end
                        end
                        else if (completed_reg >= loaded_reg)
                        begin
                            res_ev_reg    <= EV_ALL_DONE;
                            res_slot_reg  <= '0;
                            res_start_reg <= time_reg;
                            res_boost_reg <= 1'b0;
                            state_reg     <= S_FINISH;
                        end
                        else if (since_reg >= {1'b0, boost_period_reg})
                        begin
                            res_slot_reg  <= '0;
                            res_boost_reg <= 1'b1;
                            since_reg     <= '0;
                            blvl_reg      <= LV_W'(1);
                            state_reg     <= S_BLVL;
                        end
                        else
                        begin
                            res_slot_reg  <= '0;
                            res_boost_reg <= 1'b0;
                            state_reg     <= S_ADM_RD;
                        end
                    end
                end
                S_BLVL:
                begin
                    if (count_reg[blvl_reg] == '0)
                    begin
                        if (blvl_reg == LV_W'(NUM_LEVELS - 1))
                        begin
                            state_reg <= S_ADM_RD;
                        end
                        blvl_reg <= blvl_reg + LV_W'(1);
                    end
                    else
                    begin
                        cur_reg    <= head_reg[blvl_reg];
                        walk_n_reg <= count_reg[blvl_reg];
                        state_reg  <= S_BWALK;
                    end
                end
                S_BWALK:
                begin
                    if (walk_n_reg > CNT_W'(1))
                    begin
                        walk_n_reg <= walk_n_reg - CNT_W'(1);
                        state_reg  <= S_BNEXT;
                    end
                    else
                    begin
                        state_reg <= S_BSPLICE;
                    end
                end
                S_BNEXT:
                begin
                    cur_reg   <= link_rd_reg;
                    state_reg <= S_BWALK;
                end
                S_BSPLICE:
                begin
                    if (count_reg[0] == '0)
                    begin
                        head_reg[0] <= head_reg[blvl_reg];
                    end
                    tail_reg[0]         <= tail_reg[blvl_reg];
                    count_reg[0]        <= count_reg[0] + count_reg[blvl_reg];
                    count_reg[blvl_reg] <= '0;
                    blvl_reg            <= blvl_reg + LV_W'(1);
                    state_reg <= (blvl_reg == LV_W'(NUM_LEVELS - 1)) ? S_ADM_RD : S_BLVL;
                end
                S_ADM_RD:
                begin
                    state_reg <= (admitted_reg < loaded_reg) ? S_ADM_CHK : S_SEL;
                end
                S_ADM_CHK:
                begin
                    if (adm_ok)
                    begin
                        admitted_reg <= admitted_reg + CNT_W'(1);
                        state_reg    <= S_ADM_RD;
                    end
                    else
                    begin
                        state_reg <= S_SEL;
                    end
                end
                S_SEL:
                begin
                    res_start_reg <= time_reg;
                    if (any_ready)
                    begin
                        run_lv_reg   <= sel_lv;
                        run_slot_reg <= head_reg[sel_lv];
                        state_reg    <= S_EXEC1;
                    end
                    else
                    begin
                        time_reg   <= time_reg + TIME_W'(1);
                        since_reg  <= since_reg + SB_W'(1);
                        res_ev_reg <= EV_IDLE;
                        state_reg  <= S_FINISH;
                    end
                end
                S_EXEC1:
                begin
                    count_reg[run_lv_reg] <= count_reg[run_lv_reg] - CNT_W'(1);
                    if (count_reg[run_lv_reg] != CNT_W'(1))
                    begin
                        head_reg[run_lv_reg] <= link_rd_reg;
                    end
                    ex_reg    <= ({{(T_W-Q_W){1'b0}}, q_eff} < rem_rd_reg) ?
                                 q_eff : rem_rd_reg[Q_W-1:0];
                    state_reg <= S_EXEC2;
                end
                S_EXEC2:
                begin
                    time_reg     <= time_reg + TIME_W'(ex_reg);
                    since_reg    <= since_reg + SB_W'(ex_reg);
                    res_slot_reg <= run_slot_reg;
                    res_lv_reg   <= run_lv_reg;
                    res_run_reg  <= ex_reg;
                    if (rem_new == '0)
                    begin
                        completed_reg <= completed_reg + CNT_W'(1);
                        res_ev_reg    <= EV_COMPLETE;
                    end
                    else
                    begin
                        res_ev_reg <= demote ? EV_DEMOTED : EV_STAYS;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ev_reg    <= res_ev_reg;
                        out_slot_reg  <= res_slot_reg;
                        out_lv_reg    <= res_lv_reg;
                        out_start_reg <= res_start_reg;
                        out_run_reg   <= res_run_reg;
                        out_boost_reg <= res_boost_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `MLFQ_ASSERT_ALWAYS(a_counts_order,
        (completed_reg <= admitted_reg) && (admitted_reg <= loaded_reg))
    `MLFQ_ASSERT_ALWAYS(a_queue_balance,
        (state_reg != S_IDLE) ||
        (queued_sum + (CNT_W+2)'(completed_reg) == (CNT_W+2)'(admitted_reg)))
    `MLFQ_ASSERT_NEXT(a_finish_publish,
        (state_reg == S_FINISH) && (!out_valid_reg || out_ready),
        out_valid_reg && (state_reg == S_IDLE))

endmodule

FILE: sim/tb_mlfq_scheduler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_mlfq_scheduler
// Self-checking bench for the four-level feedback queue scheduler. An inline
// scheduler model predicts one result per item. A queue-fed driver and a
// monitor apply random idle bursts on both channels. Registers are written
// through the APB port between phases, once the scheduler is idle.
// ---------------------------------------------------------------------------
module tb_mlfq_scheduler;
    import mlfq_pkg::*;

    localparam int SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic        op;
        logic [15:0] arr;
        logic [15:0] len;
    } job_item_t;

    typedef struct {
        event_t      ev;
        logic [5:0]  slot;
        logic [1:0]  lv;
        logic [31:0] start;
        logic [11:0] run;
        logic        boost;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = 1'b0;
    logic [15:0] arrival = '0;
    logic [15:0] job_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_res;
    logic [5:0]  process_slot;
    logic [1:0]  level;
    logic [31:0] start_time;
    logic [11:0] run_length;
    logic        boosted;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    job_item_t     pending_jobs[$];
    sched_result_t expected_results[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    int            send_gap = 0;
    int            recv_gap = 0;
    bit            no_stalls = 0;

    int unsigned qnt[4];
    int unsigned allot[3];
    int unsigned boost_per;
    logic [15:0] remain_tab[SLOTS];
    logic [15:0] arrive_tab[SLOTS];
    logic [15:0] used_tab[SLOTS];
    logic [5:0]  link_tab[SLOTS];
    int unsigned q_head[4];
    int unsigned q_tail[4];
    int unsigned q_cnt[4];
    logic [31:0] now_time;
    logic [16:0] since_boost;
    int unsigned n_loaded;
    int unsigned n_admitted;
    int unsigned n_done;
    int unsigned gen_loads = 0;
    int unsigned gen_arrival = 0;

    mlfq_scheduler dut (.*);

    always #1 clk = ~clk;

    function automatic void enqueue(int unsigned lv, int unsigned slot);
        if (q_cnt[lv] == 0)
            q_head[lv] = slot;
        else
            link_tab[q_tail[lv]] = slot[5:0];
        q_tail[lv] = slot;
        q_cnt[lv]++;
    endfunction

    function automatic int unsigned dequeue(int unsigned lv);
        int unsigned slot;
        slot = q_head[lv];
        q_cnt[lv]--;
        if (q_cnt[lv] != 0)
            q_head[lv] = link_tab[slot];
        return slot;
    endfunction

    function automatic sched_result_t schedule_next(job_item_t it);
        sched_result_t r;
        int unsigned p, q, ex, used;
        bit found, dem;
        r = '{EV_LOADED, 6'd0, 2'd0, 32'd0, 12'd0, 1'b0};
        found = 0;
        if (it.op == OP_LOAD) begin
            if (n_loaded >= SLOTS || it.len == 0 ||
                (n_loaded > 0 && it.arr < arrive_tab[n_loaded-1])) begin
                r.ev = EV_REJECTED;
            end
            else begin
                r.slot = n_loaded[5:0];
                arrive_tab[n_loaded] = it.arr;
                remain_tab[n_loaded] = it.len;
                used_tab[n_loaded] = '0;
                n_loaded++;
            end
        end
        else if (n_done >= n_loaded) begin
            r.ev = EV_ALL_DONE;
            r.start = now_time;
        end
        else begin
            if (since_boost >= boost_per) begin
                for (int lv = 1; lv < NUM_LEVELS; lv++) begin
                    while (q_cnt[lv] != 0) begin
                        p = dequeue(lv);
                        used_tab[p] = '0;
                        enqueue(0, p);
                    end
                end
                since_boost = '0;
                r.boost = 1'b1;
            end
            while (n_admitted < n_loaded && arrive_tab[n_admitted] <= now_time) begin
                used_tab[n_admitted] = '0;
                enqueue(0, n_admitted);
                n_admitted++;
            end
            r.start = now_time;
            for (int lv = 0; lv < NUM_LEVELS && !found; lv++) begin
                if (q_cnt[lv] != 0) begin
                    found = 1;
                    p = dequeue(lv);
                    q = (qnt[lv] == 0) ? 1 : qnt[lv];
                    ex = (q < remain_tab[p]) ? q : remain_tab[p];
                    used = used_tab[p] + ex;
                    if (used > 16'hFFFF)
                        used = 16'hFFFF;
                    now_time = now_time + ex;
                    since_boost = since_boost + ex[16:0];
                    remain_tab[p] = remain_tab[p] - ex[15:0];
                    dem = (lv < NUM_LEVELS - 1) && allot[lv] != 0 && used >= allot[lv];
                    if (dem)
                        used = 0;
                    used_tab[p] = used[15:0];
                    r.slot = p[5:0];
                    r.lv = lv[1:0];
                    r.run = ex[11:0];
                    if (remain_tab[p] == 0) begin
                        n_done++;
                        r.ev = EV_COMPLETE;
                    end
                    else if (dem) begin
                        enqueue(lv + 1, p);
                        r.ev = EV_DEMOTED;
                    end
                    else begin
                        enqueue(lv, p);
                        r.ev = EV_STAYS;
                    end
                end
            end
            if (!found) begin
                now_time = now_time + 1;
                since_boost = since_boost + 17'd1;
                r.ev = EV_IDLE;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else begin
            if (in_valid && in_ready) begin
                sched_result_t pred;
                pred = schedule_next('{operation, arrival, job_length});
                expected_results = {expected_results, pred};
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_jobs.size() > 0) begin
                    job_item_t it;
                    it = pending_jobs.pop_front();
                    operation <= it.op;
                    arrival <= it.arr;
                    job_length <= it.len;
                    in_valid <= 1'b1;
                    if (!no_stalls && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 8);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: event_res %0d", event_res);
                    error_count++;
                end
                else begin
                    sched_result_t e;
                    e = expected_results.pop_front();
                    if (event_res !== e.ev) begin
                        $error("event_res: expected %0d, got %0d", e.ev, event_res);
                        error_count++;
                    end
                    if (process_slot !== e.slot) begin
                        $error("process_slot: expected %0d, got %0d", e.slot, process_slot);
                        error_count++;
                    end
                    if (level !== e.lv) begin
                        $error("level: expected %0d, got %0d", e.lv, level);
                        error_count++;
                    end
                    if (start_time !== e.start) begin
                        $error("start_time: expected %0d, got %0d", e.start, start_time);
                        error_count++;
                    end
                    if (run_length !== e.run) begin
                        $error("run_length: expected %0d, got %0d", e.run, run_length);
                        error_count++;
                    end
                    if (boosted !== e.boost) begin
                        $error("boosted: expected %0d, got %0d", e.boost, boosted);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!no_stalls && $urandom_range(0, 6) == 0) begin
                recv_gap <= $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input int unsigned val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx <= REG_QUANTUM3)
            qnt[idx] = val & 12'hFFF;
        else if (idx <= REG_ALLOT2)
            allot[idx - REG_ALLOT0] = val & 16'hFFFF;
        else
            boost_per = val & 16'hFFFF;
    endtask

    task automatic set_regs(input int unsigned q0, q1, q2, q3, a0, a1, a2, bp);
        reg_write(REG_QUANTUM0, q0);
        reg_write(REG_QUANTUM1, q1);
        reg_write(REG_QUANTUM2, q2);
        reg_write(REG_QUANTUM3, q3);
        reg_write(REG_ALLOT0, a0);
        reg_write(REG_ALLOT1, a1);
        reg_write(REG_ALLOT2, a2);
        reg_write(REG_BOOST, bp);
    endtask

    task automatic wait_drained();
        while (pending_jobs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_job(input logic op, input int unsigned arr, input int unsigned len);
        job_item_t it;
        it = '{op, arr[15:0], len[15:0]};
        pending_jobs = {pending_jobs, it};
    endtask

    task automatic random_phase(input int n);
        int unsigned pick, len;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8 && gen_loads < SLOTS + 4) begin
                gen_arrival = gen_arrival + $urandom_range(0, 30);
                if (gen_arrival > 16'hFFFF)
                    gen_arrival = 16'hFFFF;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16'hFFFF)
                                                 : $urandom_range(1, 60);
                queue_job(OP_LOAD, gen_arrival, len);
                gen_loads++;
            end
            else if (pick < 12) begin
                queue_job(OP_LOAD, $urandom_range(0, 16'hFFFF), 0);
            end
            else if (pick < 14 && gen_arrival > 0) begin
                queue_job(OP_LOAD, gen_arrival - 1, $urandom_range(1, 16'hFFFF));
            end
            else begin
                queue_job(OP_STEP, $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
            end
        end
    endtask

    initial begin
        qnt = '{4, 8, 12, 100};
        allot = '{8, 16, 48};
        boost_per = 50;
        q_head = '{default: 0};
        q_tail = '{default: 0};
        q_cnt = '{default: 0};
        now_time = '0;
        since_boost = '0;
        n_loaded = 0;
        n_admitted = 0;
        n_done = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        queue_job(OP_STEP, 0, 0);
        queue_job(OP_LOAD, 0, 1);
        queue_job(OP_LOAD, 0, 16'hFFFF);
        queue_job(OP_LOAD, 16'hFFFF, 0);
        queue_job(OP_LOAD, 5, 3);
        queue_job(OP_LOAD, 2, 4);
        queue_job(OP_LOAD, 40, 30);
        for (int k = 0; k < 16; k++)
            queue_job(OP_STEP, 16'hFFFF, 16'hFFFF);
        gen_loads = 4;
        gen_arrival = 40;
        wait_drained();

        set_regs(1, 1, 1, 1, 1, 1, 1, 1);
        random_phase(200);
        wait_drained();
        set_regs(4095, 4095, 4095, 4095, 65535, 65535, 65535, 65535);
        random_phase(200);
        wait_drained();
        set_regs(2, 3, 5, 4095, 3, 6, 65535, 40);
        random_phase(200);
        wait_drained();
        for (int ph = 0; ph < 4; ph++) begin
            set_regs($urandom_range(1, 32), $urandom_range(1, 64), $urandom_range(1, 128),
                     $urandom_range(1, 4095), $urandom_range(1, 100),
                     $urandom_range(1, 300), $urandom_range(1, 65535),
                     $urandom_range(1, 400));
            random_phase(200);
            wait_drained();
        end
        no_stalls = 1;
        set_regs(4095, 4095, 4095, 4095, 1, 65535, 1, 2);
        random_phase(240);
        wait_drained();
        repeat (300) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/mlfq_pkg.sv
sv/mlfq_scheduler.sv
sim/tb_mlfq_scheduler.sv
